@@ rtl/assert_macros.svh @@
// Assertion macros used by the top level of the spectral gain block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("assertion failed: %m");
// expr must never be true at a clock edge outside reset
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error("forbidden condition seen: %m");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, expr)
`endif
`endif

@@ rtl/wsg_pkg.sv @@
// Package of the spectral gain block: widths, constants and shared types
`default_nettype none

package wsg_pkg;

	// transform size; indices beyond half of it are clamped
	localparam int FREQ_SIZE = 1024;
	localparam int FREQ_LIM  = FREQ_SIZE / 2;

	// field widths
	localparam int FREQ_W     = 10;
	localparam int DATA_W     = 32;
	localparam int KERN_W     = 18;
	localparam int WEIGHT_W   = 24;
	localparam int COEF_W     = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// denominator path
	localparam int SQ_W      = 2 * FREQ_W - 1;        // |f|^2 <= 2^18
	localparam int KSQ_W     = 2 * KERN_W - 1;        // |k|^2 <= 2^34
	localparam int PROD_W    = COEF_W + SQ_W;         // coef * |f|^2
	localparam int SUM_W     = PROD_W;                // sum of both axes still fits
	localparam int RHO_SHIFT = 12;                    // Q.28 -> Q.16
	localparam int RHO_RND   = 1 << (RHO_SHIFT - 1);
	localparam int RHO_W     = SUM_W - RHO_SHIFT;
	localparam int TERM_W    = WEIGHT_W + RHO_W;      // lambda * rho2, Q.32
	localparam int NUM_W     = 64;                    // numerator / denominator width

	// numerator scaling: k in Q.16 -> gain Q.24 over a Q.32 denominator
	localparam int KERN_SHIFT    = 40;
	localparam int UNIT_SHIFT    = 56;                // 1.0 numerator
	localparam int ONE_DEN_SHIFT = 32;                // 1.0 in the denominator

	// gain magnitude is at most 2^40
	localparam int QUO_W = 41;
	localparam logic [QUO_W-1:0] QUO_MAX = QUO_W'(1) << KERN_SHIFT;

	// output scaling
	localparam int GAIN_FRAC = 24;
	localparam int GAIN_RND  = 1 << (GAIN_FRAC - 1);
	localparam int GL_W      = 32;                    // low gain slice
	localparam int GH_W      = QUO_W - GL_W;          // high gain slice
	localparam int PLO_W     = DATA_W + GL_W;
	localparam int HI_W      = DATA_W + GH_W;
	localparam int LO_W      = PLO_W - GAIN_FRAC;
	localparam int MAG_W     = HI_W + (GL_W - GAIN_FRAC);

	localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

	// pipeline depth
	localparam int DEN_STAGES   = 6;
	localparam int SCALE_STAGES = 4;
	localparam int LATENCY      = DEN_STAGES + QUO_W + SCALE_STAGES;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_USE_KERNEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WEIGHT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_X     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_Y     = 2'd3;

	// reset values
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT = 24'd65536;
	localparam logic [COEF_W-1:0]   RST_COEF   = 32'd40426;

	typedef struct packed {
		logic                use_kernel;
		logic [WEIGHT_W-1:0] reg_weight;
		logic [COEF_W-1:0]   coef_x;
		logic [COEF_W-1:0]   coef_y;
	} cfg_t;

	// sample magnitudes and output signs, carried alongside the gain math
	typedef struct packed {
		logic [DATA_W-1:0] re_mag;
		logic [DATA_W-1:0] im_mag;
		logic              re_neg;
		logic              im_neg;
	} side_t;

	// one divider stage: partial remainder, divisor, and the shared
	// numerator-bits / quotient-bits shift register
	typedef struct packed {
		logic [NUM_W-1:0] rem;
		logic [NUM_W-1:0] den;
		logic [QUO_W-1:0] nq;
		side_t            side;
	} div_t;

endpackage

`default_nettype wire

@@ rtl/wsg_cfg_regs.sv @@
// Configuration registers of the spectral gain block
`default_nettype none

module wsg_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr,
	input  logic [wsg_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [wsg_pkg::CFG_DATA_W-1:0] cfg_wdata,
	output wsg_pkg::cfg_t                  cfg
);
	import wsg_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.use_kernel <= 1'b0;
			cfg_q.reg_weight <= RST_WEIGHT;
			cfg_q.coef_x     <= RST_COEF;
			cfg_q.coef_y     <= RST_COEF;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_USE_KERNEL: cfg_q.use_kernel <= cfg_wdata[0];
				REG_WEIGHT:     cfg_q.reg_weight <= cfg_wdata[WEIGHT_W-1:0];
				REG_COEF_X:     cfg_q.coef_x     <= cfg_wdata[COEF_W-1:0];
				REG_COEF_Y:     cfg_q.coef_y     <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ rtl/wsg_denom.sv @@
// Front pipeline: rho2, lambda*rho2, denominator and rounded numerator
`default_nettype none

module wsg_denom (
	input  logic                              clk,
	input  logic                              arst_n,
	input  wsg_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	input  logic signed [wsg_pkg::FREQ_W-1:0] freq_x,
	input  logic signed [wsg_pkg::FREQ_W-1:0] freq_y,
	input  logic signed [wsg_pkg::DATA_W-1:0] re_in,
	input  logic signed [wsg_pkg::DATA_W-1:0] im_in,
	input  logic signed [wsg_pkg::KERN_W-1:0] kernel_gain,
	output logic                              out_valid,
	output wsg_pkg::div_t                     out_data
);
	import wsg_pkg::*;

	function automatic logic [FREQ_W-1:0] freq_mag(input logic signed [FREQ_W-1:0] f);
		logic [FREQ_W-1:0] a;
		a = f[FREQ_W-1] ? FREQ_W'(-f) : FREQ_W'(f);
		if (32'(a) > FREQ_LIM)
			a = FREQ_W'(FREQ_LIM);
		return a;
	endfunction

	// input decode
	logic [FREQ_W-1:0]   fx_mag, fy_mag;
	logic [KERN_W-1:0]   k_mag;
	logic                k_zero, g_neg;
	side_t               side0;
	logic [2*FREQ_W-1:0] fx_sq, fy_sq;
	logic [2*KERN_W-1:0] k_sq;

	always_comb begin
		fx_mag = freq_mag(freq_x);
		fy_mag = freq_mag(freq_y);
		k_mag  = kernel_gain[KERN_W-1] ? KERN_W'(-kernel_gain) : KERN_W'(kernel_gain);
		g_neg  = cfg.use_kernel & kernel_gain[KERN_W-1];
		k_zero = cfg.use_kernel & (kernel_gain == '0);
		side0.re_mag = re_in[DATA_W-1] ? DATA_W'(-re_in) : DATA_W'(re_in);
		side0.im_mag = im_in[DATA_W-1] ? DATA_W'(-im_in) : DATA_W'(im_in);
		side0.re_neg = re_in[DATA_W-1] ^ g_neg;
		side0.im_neg = im_in[DATA_W-1] ^ g_neg;
	end

	assign fx_sq = fx_mag * fx_mag;
	assign fy_sq = fy_mag * fy_mag;
	assign k_sq  = k_mag * k_mag;

	// stage registers
	logic              v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic [SQ_W-1:0]   fx2_s1, fy2_s1;
	logic [PROD_W-1:0] px_s2, py_s2;
	logic [RHO_W-1:0]  rho_s3;
	logic [TERM_W-1:0] term_s4;
	logic [KERN_W-1:0] kmag_s1, kmag_s2, kmag_s3, kmag_s4;
	logic [KSQ_W-1:0]  ksq_s1, ksq_s2, ksq_s3, ksq_s4;
	logic              kzero_s1, kzero_s2, kzero_s3, kzero_s4;
	side_t             side_s1, side_s2, side_s3, side_s4, side_s5;
	logic [NUM_W-1:0]  den_s5, base_s5;
	div_t              data_s6;

	// datapath between stages
	logic [PROD_W-1:0] px, py;
	logic [SUM_W-1:0]  sum_rnd;
	logic [TERM_W-1:0] term;
	logic [NUM_W-1:0]  den, base, num;

	assign px      = cfg.coef_x * fx2_s1;
	assign py      = cfg.coef_y * fy2_s1;
	assign sum_rnd = px_s2 + py_s2 + SUM_W'(RHO_RND);
	assign term    = cfg.reg_weight * rho_s3;

	// a zero kernel gets 0 / 1, which makes the gain zero
	always_comb begin
		if (kzero_s4) begin
			den  = NUM_W'(1);
			base = '0;
		end else if (cfg.use_kernel) begin
			den  = NUM_W'(ksq_s4) + NUM_W'(term_s4);
			base = NUM_W'(kmag_s4) << KERN_SHIFT;
		end else begin
			den  = (NUM_W'(1) << ONE_DEN_SHIFT) + NUM_W'(term_s4);
			base = NUM_W'(1) << UNIT_SHIFT;
		end
	end

	// round to nearest: add half the divisor
	assign num = base_s5 + (den_s5 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		fx2_s1   <= fx_sq[SQ_W-1:0];
		fy2_s1   <= fy_sq[SQ_W-1:0];
		kmag_s1  <= k_mag;
		ksq_s1   <= k_sq[KSQ_W-1:0];
		kzero_s1 <= k_zero;
		side_s1  <= side0;

		px_s2    <= px;
		py_s2    <= py;
		kmag_s2  <= kmag_s1;
		ksq_s2   <= ksq_s1;
		kzero_s2 <= kzero_s1;
		side_s2  <= side_s1;

		rho_s3   <= sum_rnd[SUM_W-1:RHO_SHIFT];
		kmag_s3  <= kmag_s2;
		ksq_s3   <= ksq_s2;
		kzero_s3 <= kzero_s2;
		side_s3  <= side_s2;

		term_s4  <= term;
		kmag_s4  <= kmag_s3;
		ksq_s4   <= ksq_s3;
		kzero_s4 <= kzero_s3;
		side_s4  <= side_s3;

		den_s5   <= den;
		base_s5  <= base;
		side_s5  <= side_s4;

		// quotient < 2^41, so the top numerator bits are already below den
		data_s6.rem  <= NUM_W'(num[NUM_W-1:QUO_W]);
		data_s6.den  <= den_s5;
		data_s6.nq   <= num[QUO_W-1:0];
		data_s6.side <= side_s5;
	end

	assign out_valid = v_s6;
	assign out_data  = data_s6;

endmodule

`default_nettype wire

@@ rtl/wsg_div_stage.sv @@
// One restoring-division stage: settles one quotient bit per cycle
`default_nettype none

module wsg_div_stage (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  wsg_pkg::div_t in_data,
	output logic          out_valid,
	output wsg_pkg::div_t out_data
);
	import wsg_pkg::*;

	logic [NUM_W:0] trial, diff;
	logic           take;
	div_t           next;
	logic           v_s1;
	div_t           data_s1;

	// shift the next numerator bit into the remainder and try a subtract
	assign trial = {in_data.rem, in_data.nq[QUO_W-1]};
	assign diff  = trial - {1'b0, in_data.den};
	assign take  = ~diff[NUM_W];

	always_comb begin
		next.rem  = take ? diff[NUM_W-1:0] : trial[NUM_W-1:0];
		next.den  = in_data.den;
		next.nq   = {in_data.nq[QUO_W-2:0], take};
		next.side = in_data.side;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else
			v_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		data_s1 <= next;
	end

	assign out_valid = v_s1;
	assign out_data  = data_s1;

endmodule

`default_nettype wire

@@ rtl/wsg_scale.sv @@
// Output pipeline: sample magnitude times gain, rounding, sign and saturation
`default_nettype none

module wsg_scale (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic [wsg_pkg::QUO_W-1:0]         gain,
	input  wsg_pkg::side_t                    side,
	output logic                              done,
	output logic signed [wsg_pkg::DATA_W-1:0] re_out,
	output logic signed [wsg_pkg::DATA_W-1:0] im_out
);
	import wsg_pkg::*;

	function automatic logic [DATA_W-1:0] saturate(input logic [MAG_W-1:0] mag,
		input logic neg);
		logic [DATA_W-1:0] r;
		if (neg) begin
			if (mag > MAG_W'(SAT_NEG))
				r = SAT_NEG;
			else
				r = DATA_W'(0) - mag[DATA_W-1:0];
		end else begin
			if (mag > MAG_W'(SAT_POS))
				r = SAT_POS;
			else
				r = mag[DATA_W-1:0];
		end
		return r;
	endfunction

	logic [PLO_W-1:0] plo_re, plo_im, rnd_re, rnd_im;
	logic [HI_W-1:0]  phi_re, phi_im;
	logic [MAG_W-1:0] mag_re, mag_im;

	logic              v_s1, v_s2, v_s3, v_s4;
	logic [PLO_W-1:0]  plo_re_s1, plo_im_s1;
	logic [HI_W-1:0]   phi_re_s1, phi_im_s1, hi_re_s2, hi_im_s2;
	logic [LO_W-1:0]   lo_re_s2, lo_im_s2;
	logic [MAG_W-1:0]  mag_re_s3, mag_im_s3;
	logic              neg_re_s1, neg_im_s1, neg_re_s2, neg_im_s2, neg_re_s3, neg_im_s3;
	logic [DATA_W-1:0] re_s4, im_s4;

	// gain split into a 32-bit low slice and a narrow high slice
	assign plo_re = side.re_mag * gain[GL_W-1:0];
	assign plo_im = side.im_mag * gain[GL_W-1:0];
	assign phi_re = side.re_mag * gain[QUO_W-1:GL_W];
	assign phi_im = side.im_mag * gain[QUO_W-1:GL_W];

	assign rnd_re = plo_re_s1 + PLO_W'(GAIN_RND);
	assign rnd_im = plo_im_s1 + PLO_W'(GAIN_RND);

	assign mag_re = (MAG_W'(hi_re_s2) << (GL_W - GAIN_FRAC)) + MAG_W'(lo_re_s2);
	assign mag_im = (MAG_W'(hi_im_s2) << (GL_W - GAIN_FRAC)) + MAG_W'(lo_im_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		plo_re_s1 <= plo_re;
		plo_im_s1 <= plo_im;
		phi_re_s1 <= phi_re;
		phi_im_s1 <= phi_im;
		neg_re_s1 <= side.re_neg;
		neg_im_s1 <= side.im_neg;

		lo_re_s2  <= rnd_re[PLO_W-1:GAIN_FRAC];
		lo_im_s2  <= rnd_im[PLO_W-1:GAIN_FRAC];
		hi_re_s2  <= phi_re_s1;
		hi_im_s2  <= phi_im_s1;
		neg_re_s2 <= neg_re_s1;
		neg_im_s2 <= neg_im_s1;

		mag_re_s3 <= mag_re;
		mag_im_s3 <= mag_im;
		neg_re_s3 <= neg_re_s2;
		neg_im_s3 <= neg_im_s2;

		re_s4 <= saturate(mag_re_s3, neg_re_s3);
		im_s4 <= saturate(mag_im_s3, neg_im_s3);
	end

	assign done   = v_s4;
	assign re_out = re_s4;
	assign im_out = im_s4;

endmodule

`default_nettype wire

@@ rtl/wiener_spectral_gain.sv @@
// Top level of the regularized Wiener spectral gain block
`default_nettype none

`include "assert_macros.svh"

// Regularized Wiener gain for one complex spectrum bin per clock. An item
// is taken on every edge where start is high; busy is always low since the
// pipeline never stalls. Each item's result appears on re_out / im_out with
// done high for exactly one cycle, after the item has passed through
// 6 front stages for rho2, lambda*rho2 and the rounded numerator, 41
// restoring-divider stages that settle one gain bit each and 4 output stages
// for the gain multiply, rounding and saturation. Throughput is one item
// per cycle; the receiver cannot hold results off, so it must take every
// done pulse. Registers are written through cfg_wr / cfg_addr / cfg_wdata
// and must only change while no item is in flight.
module wiener_spectral_gain (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration write port
	input  logic                                 cfg_wr,
	input  logic [wsg_pkg::CFG_IDX_W-1:0]        cfg_addr,
	input  logic [wsg_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	// item in
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [wsg_pkg::FREQ_W-1:0]    freq_x,
	input  logic signed [wsg_pkg::FREQ_W-1:0]    freq_y,
	input  logic signed [wsg_pkg::DATA_W-1:0]    re_in,
	input  logic signed [wsg_pkg::DATA_W-1:0]    im_in,
	input  logic signed [wsg_pkg::KERN_W-1:0]    kernel_gain,
	// result out
	output logic                                 done,
	output logic signed [wsg_pkg::DATA_W-1:0]    re_out,
	output logic signed [wsg_pkg::DATA_W-1:0]    im_out
);
	import wsg_pkg::*;

	cfg_t             cfg;
	logic [QUO_W:0]   div_valid;
	div_t             div_data [0:QUO_W];

	// fully pipelined, so an item is never refused
	assign busy = 1'b0;

	wsg_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_wr),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// rho2 = cx*fx^2 + cy*fy^2, den = k^2 + lambda*rho2 (or 1 + lambda*rho2),
	// numerator = |k| or 1.0 scaled, plus den/2 for round to nearest; 0 / 1 for a zero kernel
	wsg_denom u_denom (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (start),
		.freq_x      (freq_x),
		.freq_y      (freq_y),
		.re_in       (re_in),
		.im_in       (im_in),
		.kernel_gain (kernel_gain),
		.out_valid   (div_valid[0]),
		.out_data    (div_data[0])
	);

	// divider chain: stage i settles gain bit QUO_W-1-i; the numerator's
	// low bits shift out of nq as the quotient bits shift in
	for (genvar i = 0; i < QUO_W; i++) begin : g_div
		wsg_div_stage u_stage (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (div_valid[i]),
			.in_data   (div_data[i]),
			.out_valid (div_valid[i+1]),
			.out_data  (div_data[i+1])
		);
	end

	// |x| * gain / 2^24, rounded half away from zero, signed and saturated
	wsg_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid[QUO_W]),
		.gain     (div_data[QUO_W].nq),
		.side     (div_data[QUO_W].side),
		.done     (done),
		.re_out   (re_out),
		.im_out   (im_out)
	);

	// every taken item comes out as a done pulse, and no done comes without a taken item
	`ASSERT_PROP(a_item_latency, clk, arst_n, (start && !busy) |-> ##LATENCY done)
	`ASSERT_PROP(a_done_has_item, clk, arst_n, done |-> $past(start && !busy, LATENCY))
	// divider precondition: quotient fits, so the initial remainder is below den
	`ASSERT_NEVER(a_div_entry, clk, arst_n, div_valid[0] && (div_data[0].rem >= div_data[0].den))
	// gain magnitude never exceeds 2^40
	`ASSERT_PROP(a_gain_range, clk, arst_n, div_valid[QUO_W] |-> (div_data[QUO_W].nq <= QUO_MAX))

endmodule

`default_nettype wire
